/* hw/rtl/sdep_pkg.sv */
// Package for the SSE data event parser: word types, line phases, controller states,
// character constants and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package sdep_pkg;

  localparam logic       CMD_BYTE   = 1'b0;
  localparam logic       CMD_FINISH = 1'b1;

  localparam logic       KIND_DATA  = 1'b0;
  localparam logic       KIND_END   = 1'b1;

  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [2:0] TAG_LEN    = 3'd5;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_in;
  } in_word_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_CRONLY = 3'd1,
    PH_PREFIX = 3'd2,
    PH_VALUE  = 3'd3,
    PH_IGNORE = 3'd4
  } line_phase_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } ctrl_state_t;

  // What an incoming word produces: nothing, one result, or a run of held CRs
  // followed by a payload byte.
  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_ONE  = 2'd1,
    RES_RUN  = 2'd2
  } res_class_t;

  typedef struct packed {
    logic step;
    logic emit_cr;
    logic emit_byte;
    logic busy;
  } ctl_t;

  typedef struct packed {
    res_class_t res;
    logic       rem_zero;
    logic       out_free;
  } stat_t;

  // Characters of the "data:" field name, indexed by match position.
  function automatic logic [7:0] tag_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h64;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h61;
      3'd4:    c = CH_COLON;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/sdep_ctrl.sv */
// Controller of the SSE data event parser: sequences word acceptance and the
// emission of held CR runs. Depends on sdep_pkg.
`timescale 1ns / 1ps

module sdep_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sdep_pkg::stat_t stat,
  output sdep_pkg::ctl_t  ctl
);

  sdep_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdep_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    ctl.step      = 1'b0;
    ctl.emit_cr   = 1'b0;
    ctl.emit_byte = 1'b0;
    ctl.busy      = (state_r == sdep_pkg::ST_RUN);
    case (state_r)
      sdep_pkg::ST_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          ctl.step = 1'b1;
          if (stat.res == sdep_pkg::RES_RUN) begin
            state_nxt = sdep_pkg::ST_RUN;
          end
        end
      end
      sdep_pkg::ST_RUN: begin
        if (stat.out_free) begin
          if (stat.rem_zero) begin
            ctl.emit_byte = 1'b1;
            state_nxt     = sdep_pkg::ST_IDLE;
          end else begin
            ctl.emit_cr = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = sdep_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/sdep_dp.sv */
// Datapath of the SSE data event parser: line state, held CR counter, held payload
// byte and the output register. Depends on sdep_pkg.
`timescale 1ns / 1ps

module sdep_dp #(
  parameter int MAX_PENDING_CR = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sdep_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sdep_pkg::out_word_t out_data,
  input  sdep_pkg::ctl_t      ctl,
  output sdep_pkg::stat_t     stat
);

  localparam int CRW = $clog2(MAX_PENDING_CR + 1);
  localparam logic [CRW-1:0] CR_MAX = CRW'(MAX_PENDING_CR);

  sdep_pkg::line_phase_t phase_r, phase_nxt, dec_phase;
  logic [2:0]     pos_r, pos_nxt, dec_pos;
  logic [CRW-1:0] cr_r, cr_nxt, dec_cr;
  logic           vas_r, vas_nxt, dec_vas;
  logic           ne_r, ne_nxt, dec_ne;
  logic [CRW-1:0] rem_r, rem_nxt;
  logic [7:0]     held_r, held_nxt;
  logic           out_valid_r, out_valid_nxt;
  sdep_pkg::out_word_t out_r, out_nxt;

  sdep_pkg::res_class_t res;
  logic           res_kind;
  logic [7:0]     res_byte;
  logic [7:0]     b;
  logic           load;

  assign b = in_data.byte_in;

  // Decode of one incoming word against the current line state.
  always_comb begin
    dec_phase = phase_r;
    dec_pos   = pos_r;
    dec_cr    = cr_r;
    dec_vas   = vas_r;
    dec_ne    = ne_r;
    res       = sdep_pkg::RES_NONE;
    res_kind  = sdep_pkg::KIND_DATA;
    res_byte  = 8'h00;
    if (in_data.command == sdep_pkg::CMD_FINISH || b == sdep_pkg::CH_LF) begin
      if (ne_r && (in_data.command == sdep_pkg::CMD_FINISH ||
                   phase_r == sdep_pkg::PH_START || phase_r == sdep_pkg::PH_CRONLY)) begin
        res      = sdep_pkg::RES_ONE;
        res_kind = sdep_pkg::KIND_END;
        dec_ne   = 1'b0;
      end
      dec_phase = sdep_pkg::PH_START;
      dec_pos   = 3'd0;
      dec_cr    = '0;
      dec_vas   = 1'b1;
    end else begin
      case (phase_r)
        sdep_pkg::PH_START: begin
          if (b == sdep_pkg::CH_CR) begin
            dec_phase = sdep_pkg::PH_CRONLY;
          end else if (b == sdep_pkg::tag_char(3'd0)) begin
            dec_phase = sdep_pkg::PH_PREFIX;
            dec_pos   = 3'd1;
          end else begin
            dec_phase = sdep_pkg::PH_IGNORE;
          end
        end
        sdep_pkg::PH_CRONLY: begin
          if (b != sdep_pkg::CH_CR) begin
            dec_phase = sdep_pkg::PH_IGNORE;
          end
        end
        sdep_pkg::PH_PREFIX: begin
          if (pos_r < sdep_pkg::TAG_LEN && b == sdep_pkg::tag_char(pos_r)) begin
            dec_pos = pos_r + 3'd1;
            if (dec_pos == sdep_pkg::TAG_LEN) begin
              dec_phase = sdep_pkg::PH_VALUE;
              dec_vas   = 1'b1;
              dec_cr    = '0;
              if (ne_r) begin
                res      = sdep_pkg::RES_ONE;
                res_byte = sdep_pkg::CH_LF;
              end
            end
          end else begin
            dec_phase = sdep_pkg::PH_IGNORE;
          end
        end
        sdep_pkg::PH_VALUE: begin
          if (b == sdep_pkg::CH_CR) begin
            if (cr_r < CR_MAX) begin
              dec_cr = cr_r + 1'b1;
            end
          end else if (vas_r && cr_r == '0 && b == sdep_pkg::CH_SPACE) begin
            dec_vas = 1'b0;
          end else begin
            // Held CRs go out first, then the byte itself.
            if (cr_r == '0) begin
              res      = sdep_pkg::RES_ONE;
              res_byte = b;
            end else begin
              res      = sdep_pkg::RES_RUN;
              res_byte = sdep_pkg::CH_CR;
            end
            dec_cr  = '0;
            dec_vas = 1'b0;
            dec_ne  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    phase_nxt = ctl.step ? dec_phase : phase_r;
    pos_nxt   = ctl.step ? dec_pos   : pos_r;
    cr_nxt    = ctl.step ? dec_cr    : cr_r;
    vas_nxt   = ctl.step ? dec_vas   : vas_r;
    ne_nxt    = ctl.step ? dec_ne    : ne_r;
    held_nxt  = ctl.step ? b         : held_r;
    rem_nxt   = rem_r;
    if (ctl.step && res == sdep_pkg::RES_RUN) begin
      rem_nxt = cr_r - 1'b1;
    end else if (ctl.emit_cr) begin
      rem_nxt = rem_r - 1'b1;
    end
  end

  // Output register.
  always_comb begin
    load    = 1'b0;
    out_nxt = out_r;
    if (ctl.step && res != sdep_pkg::RES_NONE) begin
      load             = 1'b1;
      out_nxt.out_kind = res_kind;
      out_nxt.out_byte = res_byte;
      out_nxt.out_last = (res == sdep_pkg::RES_ONE);
    end else if (ctl.emit_cr) begin
      load             = 1'b1;
      out_nxt.out_kind = sdep_pkg::KIND_DATA;
      out_nxt.out_byte = sdep_pkg::CH_CR;
      out_nxt.out_last = 1'b0;
    end else if (ctl.emit_byte) begin
      load             = 1'b1;
      out_nxt.out_kind = sdep_pkg::KIND_DATA;
      out_nxt.out_byte = held_r;
      out_nxt.out_last = 1'b1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sdep_pkg::PH_START;
      pos_r       <= 3'd0;
      cr_r        <= '0;
      vas_r       <= 1'b1;
      ne_r        <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      cr_r        <= cr_nxt;
      vas_r       <= vas_nxt;
      ne_r        <= ne_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.res      = res;
  assign stat.rem_zero = (rem_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

/* hw/rtl/sse_data_event_parser.sv */
// Top level of the SSE data event parser: joins the controller and the datapath.
// Depends on sdep_pkg, sdep_ctrl and sdep_dp.
//
// The input channel carries one word per stream byte, or a finish command that
// closes the stream. The parser splits lines at LF, drops trailing CRs, ignores
// comments and every field other than "data:", and sends the data values out one
// byte per output word. Data lines of one event are joined with LF, and a blank
// line or a finish closes a non-empty event with an end marker word.
// out_last marks the final output word caused by an input word.
//
// Output words are registered; the first appears in the cycle after acceptance.
// Most input words cause at most one output word and the parser takes one input
// word per cycle unless a CR run or a receiver stall holds it. A payload byte that
// follows N held CRs causes N + 1 output words, issued one per cycle while the
// receiver takes them; the input stays blocked until the held byte is loaded.
// When the receiver stalls the output register holds its word and no new input
// is taken until it drains or is taken in the same cycle.
// A synchronous reset returns to the start of a line with no open event.
`timescale 1ns / 1ps

module sse_data_event_parser #(
  parameter int MAX_PENDING_CR = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdep_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sdep_pkg::out_word_t out_data
);

  // Commands from the controller and status back from the datapath.
  sdep_pkg::ctl_t  ctl;
  sdep_pkg::stat_t stat;

  sdep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  sdep_dp #(
    .MAX_PENDING_CR (MAX_PENDING_CR)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ctl       (ctl),
    .stat      (stat)
  );

  // While a CR run is being sent, no input word may be taken.
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.busy |-> !in_ready)
    else $error("input accepted during CR run");

  // An end marker is always the final word of its input and carries a zero byte.
  a_end_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_kind == sdep_pkg::KIND_END) |->
      (out_data.out_last && out_data.out_byte == 8'h00))
    else $error("malformed end marker");

  // A word that causes no CR run leaves the controller ready for the next one.
  a_single_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && stat.res != sdep_pkg::RES_RUN) |=> !ctl.busy)
    else $error("controller entered CR run without held CRs");

  // Entering a CR run always loads a non-final CR word.
  a_run_starts_with_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && stat.res == sdep_pkg::RES_RUN) |=>
      (out_valid && !out_data.out_last && out_data.out_byte == sdep_pkg::CH_CR))
    else $error("CR run did not start with a CR word");

endmodule

/* tb/sv/sdep_event_checker.sv */
// Checker for the SSE data event parser: watches both channels, predicts the
// output words of every accepted input word and compares them in order.
// Depends on sdep_pkg.
`timescale 1ns / 1ps

module sdep_event_checker #(
  parameter int MAX_PENDING_CR = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sdep_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sdep_pkg::out_word_t out_data,
  output int                  error_count,
  output int                  backlog,
  output int                  words_seen,
  output int                  results_seen,
  output int                  events_closed
);

  localparam logic [39:0] FIELD_NAME = "data:";

  // Parser state as the stream has left it.
  sdep_pkg::line_phase_t phase;
  logic [2:0]  matched;
  int          held_crs;
  logic        at_value_start;
  logic        event_open;
  int          produced;

  sdep_pkg::out_word_t event_bytes_due[$];

  task automatic expect_word(input logic kind, input logic [7:0] b);
    sdep_pkg::out_word_t w;
    w.out_kind = kind;
    w.out_byte = b;
    w.out_last = 1'b0;
    event_bytes_due.push_back(w);
    produced++;
  endtask

  task automatic start_line();
    phase          = sdep_pkg::PH_START;
    matched        = 3'd0;
    held_crs       = 0;
    at_value_start = 1'b1;
  endtask

  task automatic close_event();
    if (event_open) begin
      expect_word(sdep_pkg::KIND_END, 8'h00);
      event_open = 1'b0;
    end
  endtask

  task automatic parse_word(input sdep_pkg::in_word_t w);
    logic [7:0] b;
    sdep_pkg::out_word_t tail;
    b = w.byte_in;
    produced = 0;
    if (w.command == sdep_pkg::CMD_FINISH) begin
      start_line();
      close_event();
    end else if (b == sdep_pkg::CH_LF) begin
      if (phase == sdep_pkg::PH_START || phase == sdep_pkg::PH_CRONLY) begin
        close_event();
      end
      start_line();
    end else begin
      case (phase)
        sdep_pkg::PH_START: begin
          if (b == sdep_pkg::CH_CR) begin
            phase = sdep_pkg::PH_CRONLY;
          end else if (b == FIELD_NAME[39:32]) begin
            phase   = sdep_pkg::PH_PREFIX;
            matched = 3'd1;
          end else begin
            phase = sdep_pkg::PH_IGNORE;
          end
        end
        sdep_pkg::PH_CRONLY: begin
          if (b != sdep_pkg::CH_CR) begin
            phase = sdep_pkg::PH_IGNORE;
          end
        end
        sdep_pkg::PH_PREFIX: begin
          if (b == FIELD_NAME[32 - 8 * matched +: 8]) begin
            matched = matched + 3'd1;
            if (matched == sdep_pkg::TAG_LEN) begin
              phase          = sdep_pkg::PH_VALUE;
              at_value_start = 1'b1;
              held_crs       = 0;
              // The joining LF goes out as soon as the field name is complete.
              if (event_open) begin
                expect_word(sdep_pkg::KIND_DATA, sdep_pkg::CH_LF);
              end
            end
          end else begin
            phase = sdep_pkg::PH_IGNORE;
          end
        end
        sdep_pkg::PH_VALUE: begin
          if (b == sdep_pkg::CH_CR) begin
            if (held_crs < MAX_PENDING_CR) begin
              held_crs++;
            end
          end else if (at_value_start && held_crs == 0 && b == sdep_pkg::CH_SPACE) begin
            at_value_start = 1'b0;
          end else begin
            repeat (held_crs) expect_word(sdep_pkg::KIND_DATA, sdep_pkg::CH_CR);
            held_crs = 0;
            expect_word(sdep_pkg::KIND_DATA, b);
            at_value_start = 1'b0;
            event_open     = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (produced > 0) begin
      tail = event_bytes_due.pop_back();
      tail.out_last = 1'b1;
      event_bytes_due.push_back(tail);
    end
  endtask

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
      error_count++;
    end
  endtask

  initial begin
    error_count   = 0;
    backlog       = 0;
    words_seen    = 0;
    results_seen  = 0;
    events_closed = 0;
  end

  always @(posedge clk) begin
    sdep_pkg::out_word_t want;
    if (!rst_n) begin
      start_line();
      event_open = 1'b0;
      event_bytes_due.delete();
    end else begin
      // A result leaving now was caused by an earlier word, so it is checked first.
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.out_kind == sdep_pkg::KIND_END) begin
          events_closed++;
        end
        if (event_bytes_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual kind %0d byte %02h last %0d",
                   $time, out_data.out_kind, out_data.out_byte, out_data.out_last);
          error_count++;
        end else begin
          want = event_bytes_due.pop_front();
          check_field("out_kind", {7'd0, want.out_kind}, {7'd0, out_data.out_kind});
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("out_last", {7'd0, want.out_last}, {7'd0, out_data.out_last});
        end
      end
      if (in_valid && in_ready) begin
        words_seen++;
        parse_word(in_data);
      end
    end
    backlog = event_bytes_due.size();
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the SSE data event parser testbench: clock, reset, stimulus, receiver
// back-pressure and the verdict. Depends on sdep_pkg, sse_data_event_parser and
// sdep_event_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_CR       = 15;
  localparam int RANDOM_WORDS = 270;
  // The limit is far above a correct run even if every word brought sixteen output
  // words at the usual stall rate, plus the one long hold-off.
  localparam int LIMIT_CYCLES = 200000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  sdep_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  sdep_pkg::out_word_t out_data;

  int   cycle_count;
  int   words_offered;
  int   directed_words;
  logic sender_steady;

  int error_count;
  int backlog;
  int words_seen;
  int results_seen;
  int events_closed;

  sse_data_event_parser #(
    .MAX_PENDING_CR(MAX_CR)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  sdep_event_checker #(
    .MAX_PENDING_CR(MAX_CR)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .error_count  (error_count),
    .backlog      (backlog),
    .words_seen   (words_seen),
    .results_seen (results_seen),
    .events_closed(events_closed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
        $display("[sse_data_event_parser] ERROR");
        $finish;
      end
    end
  end

  // Receiver. It stalls on about a quarter of the cycles, once holds off for a
  // long stretch so that the output register fills and the input backs up while
  // the sender keeps offering words, and later takes everything for a while.
  initial begin : receiver
    int rx_cycle;
    int holdoff_left;
    rx_cycle     = 0;
    holdoff_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle == 200) begin
        holdoff_left = 80;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else if (rx_cycle >= 500 && rx_cycle < 900) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 24);
      end
    end
  end

  // Offers one word and returns at the edge where it is taken. A gap, when one
  // is drawn, comes before the word, so valid is never dropped and raised again
  // in the same step, and it stays high with a steady payload until accepted.
  task automatic send_word(input logic cmd, input logic [7:0] b);
    if (!sender_steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.command <= cmd;
    in_data.byte_in <= b;
    words_offered++;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(sdep_pkg::CMD_BYTE, b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  // Any byte except LF, so that a value does not end its line by accident.
  function automatic logic [7:0] value_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == sdep_pkg::CH_LF) begin
      b = 8'hF5;
    end
    return b;
  endfunction

  // A well-formed data line with random content: optional leading space, value
  // bytes mixed with held CR runs (some longer than the parser can hold), optional
  // trailing CRs, closed by LF or now and then by a finish.
  task automatic data_line();
    int len;
    send_text("data:");
    if ($urandom_range(1) == 1) begin
      send_byte(sdep_pkg::CH_SPACE);
    end
    len = $urandom_range(0, 8);
    repeat (len) begin
      case ($urandom_range(9))
        0: repeat ($urandom_range(1, 3)) send_byte(sdep_pkg::CH_CR);
        1: begin
          if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(MAX_CR - 1, MAX_CR + 3)) send_byte(sdep_pkg::CH_CR);
          end else begin
            send_byte(sdep_pkg::CH_SPACE);
          end
        end
        default: send_byte(value_byte());
      endcase
    end
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) send_byte(sdep_pkg::CH_CR);
    end
    if ($urandom_range(19) == 0) begin
      send_word(sdep_pkg::CMD_FINISH, 8'($urandom_range(255)));
    end else begin
      send_byte(sdep_pkg::CH_LF);
    end
  endtask

  // A comment or a field the parser must skip.
  task automatic other_line();
    case ($urandom_range(3))
      0: send_byte(sdep_pkg::CH_COLON);
      1: send_text("event:");
      2: send_text("id:");
      default: send_text("retry:");
    endcase
    repeat ($urandom_range(0, 4)) send_byte(value_byte());
    send_byte(sdep_pkg::CH_LF);
  endtask

  // A field name that breaks off part way, on a CR or a wrong character.
  task automatic broken_line();
    string tag;
    int    keep;
    tag  = "data:";
    keep = $urandom_range(0, 4);
    for (int i = 0; i < keep; i++) begin
      send_byte(tag[i]);
    end
    send_byte(($urandom_range(1) == 1) ? sdep_pkg::CH_CR : value_byte());
    send_text("data: x");
    send_byte(sdep_pkg::CH_LF);
  endtask

  initial begin : stimulus
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    words_offered = 0;
    sender_steady = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A finish with no open event gives nothing back.
    send_word(sdep_pkg::CMD_FINISH, 8'hFF);
    // Skipped leading space, a zero byte, a held CR released by the byte after it.
    send_text("data:");
    send_byte(sdep_pkg::CH_SPACE);
    send_byte(8'h00);
    send_byte(sdep_pkg::CH_CR);
    send_byte(8'hFF);
    send_byte(sdep_pkg::CH_LF);
    // An empty value still adds the joining LF to an open event.
    send_text("data:");
    send_byte(sdep_pkg::CH_LF);
    // A line of CRs alone counts as blank and closes the event.
    send_byte(sdep_pkg::CH_CR);
    send_byte(sdep_pkg::CH_LF);
    // Comment line, then a CR inside the field name.
    send_byte(sdep_pkg::CH_COLON);
    send_byte(sdep_pkg::CH_LF);
    send_text("d");
    send_byte(sdep_pkg::CH_CR);
    send_byte(sdep_pkg::CH_LF);
    // A CR ahead of the space keeps the space; the finish drops the held CR at the
    // end of the partial line and closes the event.
    send_text("data:");
    send_byte(sdep_pkg::CH_CR);
    send_byte(sdep_pkg::CH_SPACE);
    send_text("x");
    send_byte(sdep_pkg::CH_CR);
    send_word(sdep_pkg::CMD_FINISH, 8'h00);
    directed_words = words_offered;

    // Random part, mostly well-formed lines. A stretch in the middle has no gaps.
    while (words_offered < directed_words + RANDOM_WORDS) begin
      sender_steady = (words_offered >= directed_words + 120 &&
                       words_offered < directed_words + 200);
      case ($urandom_range(99)) inside
        [0:49]: data_line();
        [50:64]: begin
          if ($urandom_range(1) == 1) begin
            send_byte(sdep_pkg::CH_CR);
          end
          send_byte(sdep_pkg::CH_LF);
        end
        [65:74]: other_line();
        [75:84]: broken_line();
        [85:91]: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
        default: send_word(sdep_pkg::CMD_FINISH, 8'($urandom_range(255)));
      endcase
    end
    in_valid <= 1'b0;

    // Drain: every predicted word has to come back, then a short quiet spell
    // catches anything extra the parser might still send.
    while (backlog != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);

    $display("Run covered %0d input words and %0d output words, %0d of them event ends.",
             words_seen, results_seen, events_closed);
    $display("Stimulus mixed data, comment, other-field, blank, malformed and noise lines.");
    if (error_count == 0 && backlog == 0) begin
      $display("[sse_data_event_parser] OK");
    end else begin
      $display("[sse_data_event_parser] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sdep_pkg.sv
hw/rtl/sdep_ctrl.sv
hw/rtl/sdep_dp.sv
hw/rtl/sse_data_event_parser.sv
tb/sv/sdep_event_checker.sv
tb/sv/testbench.sv
